// File: rtl/core/p2r_pkg.sv
// ----------------------------------------------------------------------------
// p2r_pkg
// Shared types and constants for the pixel to RGBA8 converter.
// ----------------------------------------------------------------------------
package p2r_pkg;

    localparam int LANES     = 4;
    localparam int CH_W      = 64;
    localparam int BYTE_W    = 8;
    localparam int FMT_W     = 3;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;
    localparam int WIDE_W    = 62;
    localparam int SH_W      = 6;

    // sample format codes
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_I8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_I16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_I32 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_F32 = 3'd5;
    localparam logic [FMT_W-1:0] FMT_F64 = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BGR    = 2'd2;

    // channel count codes with special handling
    localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;

    // ceil(2^24 / 257), exact floor quotient for any 16-bit input
    localparam logic [16:0] RECIP_257 = 17'd65281;

    typedef struct packed {
        logic [FMT_W-1:0] fmt;
        logic [CNT_W-1:0] cnt;
        logic             bgr;
    } t_cfg;

endpackage

// File: rtl/core/p2r_lane.sv
// ----------------------------------------------------------------------------
// p2r_lane
// Three-stage conversion of one raw channel word to an 8-bit value.
// ----------------------------------------------------------------------------
module p2r_lane
    import p2r_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [FMT_W-1:0]  i_fmt,
    input  logic [CH_W-1:0]   i_raw,
    output logic [BYTE_W-1:0] o_byte
);

    logic [WIDE_W-1:0] r1_p,   n1_p;
    logic [SH_W-1:0]   r1_sh,  n1_sh;
    logic              r1_zero, n1_zero;
    logic              r1_sat,  n1_sat;
    logic [FMT_W-1:0]  r1_fmt;

    logic [WIDE_W-1:0] r2_p,   n2_p;
    logic [SH_W-1:0]   r2_sh;
    logic              r2_zero;
    logic              r2_sat;

    logic [BYTE_W-1:0] r3_byte, n3_byte;

    logic [16:0] x17;
    logic [33:0] q34;
    logic [31:0] u32;
    logic [23:0] m24;
    logic [7:0]  e8;
    logic [52:0] m53;
    logic [10:0] e11;
    logic [60:0] p61;
    logic [61:0] k62;
    logic        rnd_up;
    logic [32:0] fold;
    logic [WIDE_W-1:0] t62;

    // stage 1: decode and exact product
    always_comb begin
        n1_p    = '0;
        n1_sh   = '0;
        n1_zero = 1'b0;
        n1_sat  = 1'b0;
        x17     = {1'b0, i_raw[15:0] ^ ((i_fmt == FMT_I16) ? 16'h8000 : 16'h0000)};
        q34     = 34'(x17) * 34'(RECIP_257);
        u32     = i_raw[31:0] ^ 32'h8000_0000;
        m24     = {1'b1, i_raw[22:0]};
        e8      = i_raw[30:23];
        m53     = {1'b1, i_raw[51:0]};
        e11     = i_raw[62:52];
        p61     = {m53, 8'h00} - {8'h00, m53};
        case (i_fmt)
            FMT_U8: n1_p = WIDE_W'(i_raw[7:0]);
            FMT_I8: n1_p = WIDE_W'(i_raw[7:0] ^ 8'h80);
            FMT_U16, FMT_I16: begin
                n1_p  = WIDE_W'(q34);
                n1_sh = SH_W'(24);
            end
            FMT_I32: n1_p = WIDE_W'({u32, 8'h00} - {8'h00, u32});
            FMT_F32: begin
                n1_p = WIDE_W'({m24, 8'h00} - {8'h00, m24});
                if (e8 == 8'hFF) begin
                    n1_zero = (i_raw[22:0] != '0) || i_raw[31];
                    n1_sat  = 1'b1;
                end else if (i_raw[31] || e8 <= 8'd118) begin
                    n1_zero = 1'b1;
                end else if (e8 >= 8'd150) begin
                    n1_sat = 1'b1;
                end else begin
                    n1_sh = SH_W'(8'd150 - e8);
                end
            end
            FMT_F64: begin
                n1_p = WIDE_W'(p61);
                if (e11 == 11'h7FF) begin
                    n1_zero = (i_raw[51:0] != '0) || i_raw[63];
                    n1_sat  = 1'b1;
                end else if (i_raw[63] || e11 <= 11'd1013) begin
                    n1_zero = 1'b1;
                end else if (e11 >= 11'd1075) begin
                    n1_sat = 1'b1;
                end else begin
                    n1_sh = SH_W'(11'd1075 - e11);
                end
            end
            default: n1_zero = 1'b1;
        endcase
    end

    // stage 2: double rounding to 53 bits, int32 range fold
    always_comb begin
        n2_p   = r1_p;
        k62    = '0;
        rnd_up = 1'b0;
        fold   = {1'b0, r1_p[31:0]} + 33'(r1_p[39:32]);
        case (r1_fmt)
            FMT_F64: begin
                if (r1_p[60]) begin
                    rnd_up = r1_p[7] & ((|r1_p[6:0]) | r1_p[8]);
                    k62    = WIDE_W'(r1_p[60:8]) + WIDE_W'(rnd_up);
                    n2_p   = k62 << 8;
                end else begin
                    rnd_up = r1_p[6] & ((|r1_p[5:0]) | r1_p[7]);
                    k62    = WIDE_W'(r1_p[60:7]) + WIDE_W'(rnd_up);
                    n2_p   = k62 << 7;
                end
            end
            FMT_I32: begin
                n2_p = WIDE_W'(r1_p[39:32]) + WIDE_W'(fold >= 33'h0_FFFF_FFFF);
            end
            default: n2_p = r1_p;
        endcase
    end

    // stage 3: scale down and clamp
    always_comb begin
        t62 = r2_p >> r2_sh;
        if (r2_zero) begin
            n3_byte = '0;
        end else if (r2_sat || t62 >= WIDE_W'(255)) begin
            n3_byte = 8'hFF;
        end else begin
            n3_byte = t62[7:0];
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= n1_p;
            r1_sh   <= n1_sh;
            r1_zero <= n1_zero;
            r1_sat  <= n1_sat;
            r1_fmt  <= i_fmt;
            r2_p    <= n2_p;
            r2_sh   <= r1_sh;
            r2_zero <= r1_zero;
            r2_sat  <= r1_sat;
            r3_byte <= n3_byte;
        end
    end

    assign o_byte = r3_byte;

endmodule

// File: rtl/core/p2r_merge.sv
// ----------------------------------------------------------------------------
// p2r_merge
// Places converted channels into RGBA by channel count and uint8 BGR swap.
// ----------------------------------------------------------------------------
module p2r_merge
    import p2r_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_cfg                    i_cfg,
    input  logic [BYTE_W*LANES-1:0] i_lane,
    output logic [BYTE_W*LANES-1:0] o_rgba
);

    logic [BYTE_W*LANES-1:0] r_rgba, n_rgba;
    logic [BYTE_W-1:0] c0, c1, c2, c3;
    logic swap;

    // channel placement
    always_comb begin
        c0   = i_lane[7:0];
        c1   = i_lane[15:8];
        c2   = i_lane[23:16];
        c3   = i_lane[31:24];
        swap = i_cfg.bgr && (i_cfg.fmt == FMT_U8);
        case (i_cfg.cnt)
            CNT_ONE:   n_rgba = {8'hFF, c0, c0, c0};
            CNT_TWO:   n_rgba = {8'hFF, 8'h00, c1, c0};
            CNT_THREE: n_rgba = swap ? {8'hFF, c0, c1, c2} : {8'hFF, c2, c1, c0};
            default:   n_rgba = swap ? {c3, c0, c1, c2} : {c3, c2, c1, c0};
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgba <= n_rgba;
        end
    end

    assign o_rgba = r_rgba;

endmodule

// File: rtl/core/pixel_to_rgba8_converter_core.sv
// ----------------------------------------------------------------------------
// pixel_to_rgba8_converter_core
// Converts raw pixels of up to four channels to RGBA8, four lanes in parallel.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_axis   | in        | one raw pixel, channels 0..3 (64 bits each)
//  m_axis   | out       | one RGBA8 pixel
//  cfg      | in        | register index and write data
//
//  One pixel per clock unless stalled; data pass three lane stages plus the
//  merge output register. All stages advance together while the output
//  register is empty or being taken, so a stall on m_axis holds the whole
//  pipeline and drops s_axis_tready. Synchronous active-low reset clears the
//  valid chain and sets the registers to uint8, four channels, no swap.
// ----------------------------------------------------------------------------
module pixel_to_rgba8_converter_core
    import p2r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // channel_0 [63:0], channel_1 [127:64], channel_2 [191:128], channel_3 [255:192]
    input  logic [LANES*CH_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic [LANES*BYTE_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic [2:0] r_vld;
    logic r_out_vld;
    logic en;
    logic [BYTE_W*LANES-1:0] lane_bytes;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt <= FMT_U8;
            r_cfg.cnt <= CNT_W'(4);
            r_cfg.bgr <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_cfg.fmt <= i_cfg_data;
                REG_COUNT:  r_cfg.cnt <= i_cfg_data;
                REG_BGR:    r_cfg.bgr <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[1:0], s_axis_tvalid};
            r_out_vld <= r_vld[2];
        end
    end

    // one lane per channel
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        p2r_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_fmt  (r_cfg.fmt),
            .i_raw  (s_axis_tdata[g*CH_W +: CH_W]),
            .o_byte (lane_bytes[g*BYTE_W +: BYTE_W])
        );
    end

    p2r_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_lane (lane_bytes),
        .o_rgba (m_axis_tdata)
    );

endmodule
